### rtl/core/svp_pkg.sv
// shared types and constants of the servo bus position poller
package svp_pkg;

	localparam int SLOT_MAX  = 4;
	localparam int REPLY_LEN = 3;
	localparam int POS_W     = 14;
	localparam int ID_W      = 5;
	localparam int TDATA_W   = 32;

	localparam logic [POS_W-1:0] RELEASE_POS = 14'd7500;

	localparam logic [1:0] OP_SET_TARGET = 2'd0;
	localparam logic [1:0] OP_RELEASE    = 2'd1;
	localparam logic [1:0] OP_POLL       = 2'd2;
	localparam logic [1:0] OP_RX_BYTE    = 2'd3;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [2:0] CFG_SLOT_COUNT = 3'd0;
	localparam logic [2:0] CFG_SLOT0_ID   = 3'd1;
	localparam logic [2:0] CFG_SLOT1_ID   = 3'd2;
	localparam logic [2:0] CFG_SLOT2_ID   = 3'd3;
	localparam logic [2:0] CFG_SLOT3_ID   = 3'd4;
	localparam logic [2:0] CFG_POS_MIN    = 3'd5;
	localparam logic [2:0] CFG_POS_MAX    = 3'd6;

	localparam logic [2:0] STEP_ERR      = 3'd0;
	localparam logic [2:0] STEP_HDR      = 3'd1;
	localparam logic [2:0] STEP_HI       = 3'd2;
	localparam logic [2:0] STEP_LO       = 3'd3;
	localparam logic [2:0] STEP_REP_LAST = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHK_HI,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             tgt_we;
		logic [ID_W-1:0]  tgt_id;
		logic [POS_W-1:0] tgt_val;
		logic             act;
		logic             pos_we;
		logic [ID_W-1:0]  pos_id;
		logic [POS_W-1:0] pos_val;
	} tbl_wr_t;

endpackage

### rtl/core/svp_tables.sv
// target, active flag and position tables of the servo bus position poller
module svp_tables #(
	parameter int ID_COUNT = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  svp_pkg::tbl_wr_t           wr,
	input  logic [svp_pkg::ID_W-1:0]   tgt_rd_id,
	output logic [svp_pkg::POS_W-1:0]  tgt_rd,
	input  logic [2:0]                 rep_idx,
	output logic [svp_pkg::POS_W-1:0]  rep_pos
);

	localparam int IDW = $clog2(ID_COUNT);

	logic [svp_pkg::POS_W-1:0] tgt_q [ID_COUNT];
	logic [svp_pkg::POS_W-1:0] pos_q [ID_COUNT];
	logic [ID_COUNT-1:0]       act_q;
	logic [svp_pkg::ID_W-1:0]  rep_id5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ID_COUNT; i++) begin
				tgt_q[i] <= '0;
				pos_q[i] <= '0;
			end
			act_q <= '0;
		end else begin
			if (wr.tgt_we && (int'(wr.tgt_id) < ID_COUNT)) begin
				tgt_q[wr.tgt_id[IDW-1:0]] <= wr.tgt_val;
				act_q[wr.tgt_id[IDW-1:0]] <= wr.act;
			end
			if (wr.pos_we && (int'(wr.pos_id) < ID_COUNT)) begin
				pos_q[wr.pos_id[IDW-1:0]] <= wr.pos_val;
			end
		end
	end

	assign rep_id5 = {2'b00, rep_idx};

	always_comb begin
		tgt_rd = '0;
		if ((int'(tgt_rd_id) < ID_COUNT) && act_q[tgt_rd_id[IDW-1:0]]) begin
			tgt_rd = tgt_q[tgt_rd_id[IDW-1:0]];
		end
		rep_pos = '0;
		if (int'(rep_id5) < ID_COUNT) begin
			rep_pos = pos_q[rep_id5[IDW-1:0]];
		end
	end

endmodule

### rtl/core/servo_bus_position_poller_core.sv
// servo bus position poller: set-target, release, receive and poll sequencer
// set-target: low limit checked in EXEC, high limit checked and target written in CHK_HI; release and rx byte in EXEC
// poll tick: one result a cycle, 3 to 8 results, held by output stalls
// one item at a time; the shared limit comparator and the result step counter set the rate
// reset: asynchronous, clears tables, reply state and slot index, loads register defaults
module servo_bus_position_poller_core #(
	parameter int ID_COUNT = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [svp_pkg::TDATA_W-1:0]   s_tdata,   // servo address, target_value, rx_byte
	input  logic [1:0]                    s_tuser,   // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [svp_pkg::TDATA_W-1:0]   m_tdata,   // tx_byte, report_id, report_position
	output logic [1:0]                    m_tuser,   // kind
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [svp_pkg::POS_W-1:0]     cfg_wdata
);

	localparam int SLOT_LIM = (svp_pkg::SLOT_MAX < 4) ? svp_pkg::SLOT_MAX : 4;
	localparam logic [2:0] LIM = 3'(SLOT_LIM);
	localparam logic [1:0] REPLY_FULL = 2'(svp_pkg::REPLY_LEN);

	svp_pkg::state_t state_q, state_d;

	logic [2:0]                slot_count_q;
	logic [svp_pkg::ID_W-1:0]  slot_id_q [4];
	logic [svp_pkg::POS_W-1:0] pos_min_q, pos_max_q;

	logic [1:0]                op_q;
	logic [svp_pkg::ID_W-1:0]  sid_q;
	logic [svp_pkg::POS_W-1:0] tv_q;
	logic [7:0]                rx_q;

	logic [1:0]                slot_index_q;
	logic                      awaiting_q;
	logic [1:0]                reply_count_q;
	logic [7:0]                reply_q [svp_pkg::REPLY_LEN];

	logic                      lo_ok_q;
	logic                      err_q;
	logic [1:0]                slot_q;
	logic [svp_pkg::ID_W-1:0]  id_q;
	logic [2:0]                step_q;

	logic                      m_tvalid_q, m_tlast_q;
	logic [1:0]                m_tuser_q;
	logic [svp_pkg::TDATA_W-1:0] m_tdata_q;

	logic                      accept;
	logic [svp_pkg::POS_W-1:0] cmp_a, cmp_b;
	logic                      cmp_le;
	logic [2:0]                eff_cnt;
	logic [1:0]                slot_sel;
	logic [1:0]                slot_next;
	logic                      reply_done;
	logic                      emit_go, emit_last;
	logic [1:0]                emit_kind;
	logic [7:0]                emit_tx;
	logic [svp_pkg::ID_W-1:0]  emit_rid;
	logic [svp_pkg::POS_W-1:0] emit_pos;
	logic [2:0]                rep_idx;
	logic [svp_pkg::POS_W-1:0] tgt_rd, rep_pos;
	svp_pkg::tbl_wr_t          wr;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == svp_pkg::ST_IDLE);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// shared limit comparator
	assign cmp_a  = (state_q == svp_pkg::ST_CHK_HI) ? tv_q : pos_min_q;
	assign cmp_b  = (state_q == svp_pkg::ST_CHK_HI) ? pos_max_q : tv_q;
	assign cmp_le = (cmp_a <= cmp_b);

	always_comb begin
		eff_cnt = slot_count_q;
		if (eff_cnt == 3'd0) eff_cnt = 3'd1;
		if (eff_cnt > LIM)   eff_cnt = LIM;
	end

	assign slot_sel   = ({1'b0, slot_index_q} < eff_cnt) ? slot_index_q : 2'd0;
	assign slot_next  = ({1'b0, slot_sel} + 3'd1 == eff_cnt) ? 2'd0 : slot_sel + 2'd1;
	assign reply_done = (reply_count_q >= REPLY_FULL);

	assign rep_idx   = step_q - svp_pkg::STEP_LO;
	assign emit_go   = (state_q == svp_pkg::ST_EMIT) && (!m_tvalid_q || m_tready);
	assign emit_last = ((step_q == svp_pkg::STEP_LO) && (slot_q != 2'd0)) ||
	                   (step_q == svp_pkg::STEP_REP_LAST);

	svp_tables #(.ID_COUNT(ID_COUNT)) u_tables (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.tgt_rd_id (id_q),
		.tgt_rd    (tgt_rd),
		.rep_idx   (rep_idx),
		.rep_pos   (rep_pos)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			svp_pkg::ST_IDLE: begin
				if (accept) state_d = svp_pkg::ST_EXEC;
			end
			svp_pkg::ST_EXEC: begin
				case (op_q)
					svp_pkg::OP_SET_TARGET: state_d = svp_pkg::ST_CHK_HI;
					svp_pkg::OP_POLL:       state_d = svp_pkg::ST_EMIT;
					default:                state_d = svp_pkg::ST_IDLE;
				endcase
			end
			svp_pkg::ST_CHK_HI: state_d = svp_pkg::ST_IDLE;
			svp_pkg::ST_EMIT: begin
				if (emit_go && emit_last) state_d = svp_pkg::ST_IDLE;
			end
			default: state_d = svp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		wr         = '0;
		wr.tgt_id  = sid_q;
		wr.pos_id  = reply_q[0][svp_pkg::ID_W-1:0];
		wr.pos_val = {reply_q[1][6:0], reply_q[2][6:0]};
		case (state_q)
			svp_pkg::ST_EXEC: begin
				if (op_q == svp_pkg::OP_RELEASE) begin
					wr.tgt_we  = 1'b1;
					wr.tgt_val = svp_pkg::RELEASE_POS;
					wr.act     = 1'b0;
				end
				if (op_q == svp_pkg::OP_POLL) begin
					wr.pos_we = awaiting_q && reply_done;
				end
			end
			svp_pkg::ST_CHK_HI: begin
				wr.tgt_we  = lo_ok_q && cmp_le;
				wr.tgt_val = tv_q;
				wr.act     = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		emit_kind = svp_pkg::KIND_TX;
		emit_tx   = '0;
		emit_rid  = '0;
		emit_pos  = '0;
		case (step_q)
			svp_pkg::STEP_ERR: emit_kind = svp_pkg::KIND_ERROR;
			svp_pkg::STEP_HDR: emit_tx   = {3'b100, id_q};
			svp_pkg::STEP_HI:  emit_tx   = {1'b0, tgt_rd[13:7]};
			svp_pkg::STEP_LO:  emit_tx   = {1'b0, tgt_rd[6:0]};
			default: begin
				emit_kind = svp_pkg::KIND_REPORT;
				emit_rid  = {2'b00, rep_idx};
				emit_pos  = rep_pos;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= svp_pkg::ST_IDLE;
			slot_count_q  <= 3'd4;
			slot_id_q[0]  <= 5'd1;
			slot_id_q[1]  <= 5'd2;
			slot_id_q[2]  <= 5'd3;
			slot_id_q[3]  <= 5'd4;
			pos_min_q     <= 14'd3500;
			pos_max_q     <= 14'd11500;
			op_q          <= svp_pkg::OP_SET_TARGET;
			slot_index_q  <= '0;
			awaiting_q    <= 1'b0;
			reply_count_q <= '0;
			lo_ok_q       <= 1'b0;
			err_q         <= 1'b0;
			slot_q        <= '0;
			step_q        <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					svp_pkg::CFG_SLOT_COUNT: slot_count_q <= cfg_wdata[2:0];
					svp_pkg::CFG_SLOT0_ID:   slot_id_q[0] <= cfg_wdata[4:0];
					svp_pkg::CFG_SLOT1_ID:   slot_id_q[1] <= cfg_wdata[4:0];
					svp_pkg::CFG_SLOT2_ID:   slot_id_q[2] <= cfg_wdata[4:0];
					svp_pkg::CFG_SLOT3_ID:   slot_id_q[3] <= cfg_wdata[4:0];
					svp_pkg::CFG_POS_MIN:    pos_min_q    <= cfg_wdata;
					svp_pkg::CFG_POS_MAX:    pos_max_q    <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (accept) op_q <= s_tuser;
			if (state_q == svp_pkg::ST_EXEC) begin
				case (op_q)
					svp_pkg::OP_SET_TARGET: lo_ok_q <= cmp_le;
					svp_pkg::OP_RX_BYTE: begin
						if (awaiting_q && !reply_done) reply_count_q <= reply_count_q + 2'd1;
					end
					svp_pkg::OP_POLL: begin
						err_q         <= awaiting_q && !reply_done;
						step_q        <= (awaiting_q && !reply_done) ? svp_pkg::STEP_ERR
						                                             : svp_pkg::STEP_HDR;
						slot_q        <= slot_sel;
						slot_index_q  <= slot_next;
						awaiting_q    <= 1'b1;
						reply_count_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (emit_go) begin
				step_q <= step_q + 3'd1;
			end
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sid_q <= s_tdata[4:0];
			tv_q  <= s_tdata[18:5];
			rx_q  <= s_tdata[26:19];
		end
		if (state_q == svp_pkg::ST_EXEC) begin
			if ((op_q == svp_pkg::OP_RX_BYTE) && awaiting_q && !reply_done) begin
				reply_q[reply_count_q] <= rx_q;
			end
			if (op_q == svp_pkg::OP_POLL) begin
				id_q <= slot_id_q[slot_sel];
				for (int i = 0; i < svp_pkg::REPLY_LEN; i++) reply_q[i] <= '0;
			end
		end
		if (emit_go) begin
			m_tuser_q <= emit_kind;
			m_tlast_q <= emit_last;
			m_tdata_q <= {5'b00000, emit_pos, emit_rid, emit_tx};
		end
	end

`ifndef ASSERT_OFF
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!awaiting_q |-> (reply_count_q == 2'd0))
		else $error("reply bytes counted outside a reply window");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && emit_last) |=> (state_q == svp_pkg::ST_IDLE) && m_tvalid && m_tlast)
		else $error("final result did not close the item");

	a_no_reports: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == svp_pkg::ST_EMIT) && (slot_q != 2'd0)) |-> (step_q <= svp_pkg::STEP_LO))
		else $error("position report outside slot zero");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svp_pkg::ST_EMIT) |-> ({1'b0, slot_index_q} < eff_cnt))
		else $error("slot index beyond slot count");

	a_err_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == svp_pkg::ST_EMIT) && !err_q) |-> (step_q != svp_pkg::STEP_ERR))
		else $error("receive error emitted without a missing reply");
`endif

endmodule

### verif/servo_poll_checker.sv
// checker for the servo bus poller: predicts results of accepted items and compares them
module servo_poll_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [svp_pkg::TDATA_W-1:0] s_tdata,   // servo address, target_value, rx_byte
	input  logic [1:0]                  s_tuser,   // op
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [svp_pkg::TDATA_W-1:0] m_tdata,   // tx_byte, report_id, report_position
	input  logic [1:0]                  m_tuser,   // kind
	input  logic                        m_tlast,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [svp_pkg::POS_W-1:0]   cfg_wdata,
	output int                          fail_count,
	output int                          pending,
	output int                          results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SERVO_IDS = 32;

	typedef struct packed {
		logic [1:0]                kind;
		logic [7:0]                tx_byte;
		logic [svp_pkg::ID_W-1:0]  report_id;
		logic [svp_pkg::POS_W-1:0] report_position;
		logic                      last;
	} poll_result_t;

	poll_result_t bus_results[$];

	logic [2:0]                slot_count;
	logic [svp_pkg::ID_W-1:0]  slot_ids [svp_pkg::SLOT_MAX];
	logic [svp_pkg::POS_W-1:0] pos_lo;
	logic [svp_pkg::POS_W-1:0] pos_hi;
	logic [svp_pkg::POS_W-1:0] target_tbl [SERVO_IDS];
	logic                      active [SERVO_IDS];
	logic [svp_pkg::POS_W-1:0] position_tbl [SERVO_IDS];
	int unsigned               slot_index;
	logic                      awaiting_reply;
	logic [7:0]                reply_buf [svp_pkg::REPLY_LEN];
	int unsigned               reply_count;

	function automatic void reset_model();
		slot_count = 3'd4;
		for (int i = 0; i < svp_pkg::SLOT_MAX; i++)
			slot_ids[i] = svp_pkg::ID_W'(i + 1);
		pos_lo = 14'd3500;
		pos_hi = 14'd11500;
		for (int i = 0; i < SERVO_IDS; i++) begin
			target_tbl[i] = '0;
			active[i] = 1'b0;
			position_tbl[i] = '0;
		end
		slot_index = 0;
		awaiting_reply = 1'b0;
		for (int i = 0; i < svp_pkg::REPLY_LEN; i++)
			reply_buf[i] = '0;
		reply_count = 0;
		bus_results.delete();
	endfunction

	function automatic void apply_write(input logic [2:0] idx,
			input logic [svp_pkg::POS_W-1:0] val);
		case (idx)
		svp_pkg::CFG_SLOT_COUNT: slot_count = val[2:0];
		svp_pkg::CFG_SLOT0_ID:   slot_ids[0] = val[svp_pkg::ID_W-1:0];
		svp_pkg::CFG_SLOT1_ID:   slot_ids[1] = val[svp_pkg::ID_W-1:0];
		svp_pkg::CFG_SLOT2_ID:   slot_ids[2] = val[svp_pkg::ID_W-1:0];
		svp_pkg::CFG_SLOT3_ID:   slot_ids[3] = val[svp_pkg::ID_W-1:0];
		svp_pkg::CFG_POS_MIN:    pos_lo = val;
		svp_pkg::CFG_POS_MAX:    pos_hi = val;
		default: ;
		endcase
	endfunction

	function automatic poll_result_t make_result(input logic [1:0] kind, input logic [7:0] tx,
			input logic [svp_pkg::ID_W-1:0] rid, input logic [svp_pkg::POS_W-1:0] rpos);
		poll_result_t r;
		r.kind = kind;
		r.tx_byte = tx;
		r.report_id = rid;
		r.report_position = rpos;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void predict_item(input logic [1:0] op,
			input logic [svp_pkg::TDATA_W-1:0] d);
		logic [svp_pkg::ID_W-1:0]  sid;
		logic [svp_pkg::POS_W-1:0] tv;
		logic [7:0]                rx;
		poll_result_t              res [8];
		int                        n;
		int                        k;
		int unsigned               cnt;
		int unsigned               slot;
		logic [svp_pkg::ID_W-1:0]  id;
		logic [svp_pkg::POS_W-1:0] tgt;
		sid = d[4:0];
		tv = d[18:5];
		rx = d[26:19];
		n = 0;
		case (op)
		svp_pkg::OP_SET_TARGET: begin
			if (pos_lo <= tv && tv <= pos_hi) begin
				active[sid] = 1'b1;
				target_tbl[sid] = tv;
			end
		end
		svp_pkg::OP_RELEASE: begin
			active[sid] = 1'b0;
			target_tbl[sid] = svp_pkg::RELEASE_POS;
		end
		svp_pkg::OP_RX_BYTE: begin
			if (awaiting_reply && reply_count < svp_pkg::REPLY_LEN) begin
				reply_buf[reply_count] = rx;
				reply_count++;
			end
		end
		svp_pkg::OP_POLL: begin
			if (slot_count == 3'd0)
				cnt = 1;
			else if (slot_count > svp_pkg::SLOT_MAX)
				cnt = svp_pkg::SLOT_MAX;
			else
				cnt = slot_count;
			slot = (slot_index < cnt) ? slot_index : 0;
			id = slot_ids[slot];
			if (awaiting_reply) begin
				if (reply_count >= svp_pkg::REPLY_LEN) begin
					position_tbl[reply_buf[0][4:0]] = {reply_buf[1][6:0], reply_buf[2][6:0]};
				end else begin
					res[n] = make_result(svp_pkg::KIND_ERROR, '0, '0, '0);
					n++;
				end
			end
			tgt = active[id] ? target_tbl[id] : '0;
			res[n] = make_result(svp_pkg::KIND_TX, {3'b100, id}, '0, '0);
			res[n + 1] = make_result(svp_pkg::KIND_TX, {1'b0, tgt[13:7]}, '0, '0);
			res[n + 2] = make_result(svp_pkg::KIND_TX, {1'b0, tgt[6:0]}, '0, '0);
			n += 3;
			awaiting_reply = 1'b1;
			reply_count = 0;
			for (k = 0; k < svp_pkg::REPLY_LEN; k++)
				reply_buf[k] = '0;
			slot_index = (slot + 1) % cnt;
			if (slot == 0) begin
				for (k = 1; k <= 4; k++) begin
					res[n] = make_result(svp_pkg::KIND_REPORT, '0, svp_pkg::ID_W'(k),
						position_tbl[k]);
					n++;
				end
			end
			res[n - 1].last = 1'b1;
			for (k = 0; k < n; k++)
				bus_results.push_back(res[k]);
		end
		default: ;
		endcase
	endfunction

	function automatic void check_result();
		poll_result_t seen;
		poll_result_t want;
		seen.kind = m_tuser;
		seen.tx_byte = m_tdata[7:0];
		seen.report_id = m_tdata[12:8];
		seen.report_position = m_tdata[26:13];
		seen.last = m_tlast;
		results_checked++;
		if (bus_results.size() == 0) begin
			if (fail_count < 10)
				$display("unexpected result: kind %0d tx %02h id %0d pos %0d last %0b",
					seen.kind, seen.tx_byte, seen.report_id, seen.report_position, seen.last);
			fail_count++;
		end else begin
			want = bus_results.pop_front();
			if (seen !== want) begin
				if (fail_count < 10) begin
					$display("result %0d mismatch at %0t", results_checked, $realtime);
					$display("  expected kind %0d tx %02h id %0d pos %0d last %0b",
						want.kind, want.tx_byte, want.report_id, want.report_position,
						want.last);
					$display("  actual   kind %0d tx %02h id %0d pos %0d last %0b",
						seen.kind, seen.tx_byte, seen.report_id, seen.report_position,
						seen.last);
				end
				fail_count++;
			end
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			reset_model();
		end else begin
			if (cfg_we)
				apply_write(cfg_index, cfg_wdata);
			if (s_tvalid && s_tready)
				predict_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				check_result();
		end
		pending = bus_results.size();
	end

endmodule

### verif/testbench.sv
// testbench top: clock, reset, register phases and item stimulus for the servo bus poller
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RX_HOLD_CYCLES = 300;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [svp_pkg::TDATA_W-1:0] s_tdata = '0;
	logic [1:0]                  s_tuser = svp_pkg::OP_SET_TARGET;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [svp_pkg::TDATA_W-1:0] m_tdata;
	logic [1:0]                  m_tuser;
	logic                        m_tlast;
	logic                        cfg_we = 1'b0;
	logic [2:0]                  cfg_index = svp_pkg::CFG_SLOT_COUNT;
	logic [svp_pkg::POS_W-1:0]   cfg_wdata = '0;

	int fail_count;
	int pending;
	int results_checked;
	int items_sent = 0;
	int phases_run = 0;
	bit no_gaps = 1'b0;
	bit hold_request = 1'b0;

	logic [svp_pkg::POS_W-1:0] lim_lo = 14'd3500;
	logic [svp_pkg::POS_W-1:0] lim_hi = 14'd11500;
	logic [svp_pkg::ID_W-1:0]  slot_id_cfg [4] = '{5'd1, 5'd2, 5'd3, 5'd4};

	servo_bus_position_poller_core dut (.*);
	servo_poll_checker result_check (.*);

	always #4 clk = ~clk;

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= no_gaps || ($urandom_range(99) >= 34);
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [svp_pkg::ID_W-1:0] sid,
			input logic [svp_pkg::POS_W-1:0] tv, input logic [7:0] rx);
		while (!no_gaps && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, rx, tv, sid};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_poll();
		send_item(svp_pkg::OP_POLL, 5'($urandom_range(31)), 14'($urandom_range(16383)),
			8'($urandom_range(255)));
	endtask

	task automatic send_rx(input logic [7:0] rx);
		send_item(svp_pkg::OP_RX_BYTE, 5'($urandom_range(31)), 14'($urandom_range(16383)),
			rx);
	endtask

	task automatic send_set(input logic [svp_pkg::ID_W-1:0] sid,
			input logic [svp_pkg::POS_W-1:0] tv);
		send_item(svp_pkg::OP_SET_TARGET, sid, tv, 8'($urandom_range(255)));
	endtask

	task automatic send_release(input logic [svp_pkg::ID_W-1:0] sid);
		send_item(svp_pkg::OP_RELEASE, sid, 14'($urandom_range(16383)),
			8'($urandom_range(255)));
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [svp_pkg::POS_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
		svp_pkg::CFG_SLOT0_ID: slot_id_cfg[0] = val[svp_pkg::ID_W-1:0];
		svp_pkg::CFG_SLOT1_ID: slot_id_cfg[1] = val[svp_pkg::ID_W-1:0];
		svp_pkg::CFG_SLOT2_ID: slot_id_cfg[2] = val[svp_pkg::ID_W-1:0];
		svp_pkg::CFG_SLOT3_ID: slot_id_cfg[3] = val[svp_pkg::ID_W-1:0];
		svp_pkg::CFG_POS_MIN:  lim_lo = val;
		svp_pkg::CFG_POS_MAX:  lim_hi = val;
		default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(input logic [2:0] cnt, input logic [svp_pkg::ID_W-1:0] id0,
			input logic [svp_pkg::ID_W-1:0] id1, input logic [svp_pkg::ID_W-1:0] id2,
			input logic [svp_pkg::ID_W-1:0] id3, input logic [svp_pkg::POS_W-1:0] lo,
			input logic [svp_pkg::POS_W-1:0] hi);
		write_reg(svp_pkg::CFG_SLOT_COUNT, svp_pkg::POS_W'(cnt));
		write_reg(svp_pkg::CFG_SLOT0_ID, svp_pkg::POS_W'(id0));
		write_reg(svp_pkg::CFG_SLOT1_ID, svp_pkg::POS_W'(id1));
		write_reg(svp_pkg::CFG_SLOT2_ID, svp_pkg::POS_W'(id2));
		write_reg(svp_pkg::CFG_SLOT3_ID, svp_pkg::POS_W'(id3));
		write_reg(svp_pkg::CFG_POS_MIN, lo);
		write_reg(svp_pkg::CFG_POS_MAX, hi);
		phases_run++;
	endtask

	// no results outstanding, then room for a late table write to land
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [svp_pkg::ID_W-1:0] pick_id();
		if ($urandom_range(9) < 7)
			return slot_id_cfg[$urandom_range(3)];
		return 5'($urandom_range(31));
	endfunction

	function automatic logic [svp_pkg::POS_W-1:0] pick_target();
		case ($urandom_range(5))
		0: return lim_lo;
		1: return lim_hi;
		2: return lim_lo - 14'd1;
		3: return lim_hi + 14'd1;
		4: return (lim_lo <= lim_hi) ? 14'($urandom_range(lim_hi, lim_lo)) : lim_lo;
		default: return 14'($urandom_range(16383));
		endcase
	endfunction

	function automatic logic [7:0] reply_byte(input int pos);
		if (pos == 0)
			return {3'($urandom_range(7)), pick_id()};
		return 8'($urandom_range(255));
	endfunction

	task automatic random_exchange();
		int pick;
		int nbytes;
		pick = $urandom_range(99);
		if (pick < 50) begin
			send_poll();
			nbytes = ($urandom_range(9) == 0) ? $urandom_range(5) : svp_pkg::REPLY_LEN;
			for (int i = 0; i < nbytes; i++)
				send_rx(reply_byte(i));
		end else if (pick < 70) begin
			send_set(pick_id(), pick_target());
		end else if (pick < 80) begin
			send_release(pick_id());
		end else if (pick < 90) begin
			send_poll();
		end else begin
			send_rx(8'($urandom_range(255)));
		end
	endtask

	task automatic run_random(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			random_exchange();
	endtask

	initial begin
		logic [svp_pkg::POS_W-1:0] lo_pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// byte before any send is dropped, first poll reports cleared positions
		send_rx(8'hff);
		send_poll();
		send_set(5'd1, 14'd3500);
		send_set(5'd2, 14'd11500);
		send_set(5'd3, 14'd3499);
		send_set(5'd4, 14'd11501);
		send_set(5'd31, 14'd16383);
		send_set(5'd0, 14'd0);
		// full reply plus one byte past the window
		send_rx(8'he2);
		send_rx(8'hff);
		send_rx(8'hff);
		send_rx(8'h55);
		send_poll();
		send_release(5'd2);
		// no reply, then a short reply
		send_poll();
		send_rx(8'h01);
		send_rx(8'h7f);
		send_poll();
		send_rx(8'h81);
		send_rx(8'h00);
		send_rx(8'h7f);
		send_set(5'd4, 14'd8000);
		send_poll();
		wait_drained();

		set_all(3'd1, 5'd0, 5'd31, 5'd0, 5'd31, 14'd0, 14'd16383);
		run_random(26);
		wait_drained();

		// slot count zero and inverted limits
		set_all(3'd0, 5'd31, 5'd0, 5'd17, 5'd9, 14'd16383, 14'd0);
		run_random(22);
		wait_drained();

		set_all(3'd7, 5'($urandom_range(31)), 5'($urandom_range(31)),
			5'($urandom_range(31)), 5'($urandom_range(31)), 14'd3500, 14'd11500);
		no_gaps = 1'b1;
		hold_request = 1'b1;
		repeat (14) send_poll();
		run_random(18);
		no_gaps = 1'b0;
		run_random(8);
		wait_drained();

		lo_pick = 14'($urandom_range(16383));
		set_all(3'd5, 5'($urandom_range(31)), 5'($urandom_range(31)),
			5'($urandom_range(31)), 5'($urandom_range(31)), lo_pick, lo_pick);
		run_random(22);
		wait_drained();

		lo_pick = 14'($urandom_range(8000));
		set_all(3'd2, 5'($urandom_range(31)), 5'($urandom_range(31)),
			5'($urandom_range(31)), 5'($urandom_range(31)), lo_pick,
			14'($urandom_range(16383, lo_pick)));
		run_random(28);
		wait_drained();

		set_all(3'd3, 5'd1, 5'd2, 5'd3, 5'd4, 14'd3500, 14'd11500);
		run_random(14);
		wait_drained();

		$display("run covered %0d items over %0d register settings, %0d results checked",
			items_sent, phases_run, results_checked);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
